/* design/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ITOA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs during reset
`define ITOA_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/itoa_pkg.sv */
// shared types and constants of the integer to ascii formatter
// no dependencies
`timescale 1ns / 1ps

package itoa_pkg;

  // opcode field
  localparam logic [1:0] OP_HEX_LOWER = 2'd0;
  localparam logic [1:0] OP_HEX_UPPER = 2'd1;
  localparam logic [1:0] OP_DEC       = 2'd2;

  // size_code field
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // flag bits
  localparam int FLAG_PAD    = 0;
  localparam int FLAG_PREFIX = 1;

  // ascii codes
  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_UPPER = 7'h41;
  localparam logic [6:0] CH_LOWER = 7'h61;

  // command queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    K_HEX,
    K_DEC,
    K_ERR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;    // masked for decimal, raw for hex
    logic        upper;
    logic        prefix;
    logic [2:0]  hex_top;  // first hex nibble to print
  } cmd_t;

endpackage

/* design/itoa_front.sv */
// front end: takes items, classifies them and builds queue commands
// depends on itoa_pkg
`timescale 1ns / 1ps

module itoa_front (
  input  logic              src_valid,
  output logic              src_stall,
  input  logic [31:0]       value,
  input  logic [1:0]        size_code,
  input  logic [1:0]        opcode,
  input  logic [1:0]        flags,
  input  logic              q_full,
  output logic              q_push,
  output itoa_pkg::cmd_t    q_cmd
);
  import itoa_pkg::*;

  logic [31:0] masked;
  logic [2:0]  nib_max;
  logic [2:0]  top_found;
  kind_t       kind;

  always_comb begin
    case (size_code)
      SZ_BYTE: begin
        masked  = {24'b0, value[7:0]};
        nib_max = 3'd1;
      end
      SZ_HALF: begin
        masked  = {16'b0, value[15:0]};
        nib_max = 3'd3;
      end
      default: begin
        masked  = value;
        nib_max = 3'd7;
      end
    endcase
  end

  always_comb begin
    if (opcode == OP_DEC) begin
      kind = K_DEC;
    end else if ((opcode == OP_HEX_LOWER || opcode == OP_HEX_UPPER) &&
                 size_code inside {SZ_BYTE, SZ_HALF, SZ_WORD}) begin
      kind = K_HEX;
    end else begin
      kind = K_ERR;
    end
  end

  // highest nonzero nibble within the chosen size, zero if none
  always_comb begin
    top_found = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) <= nib_max && value[4*i +: 4] != 4'd0) begin
        top_found = 3'(i);
      end
    end
  end

  always_comb begin
    q_cmd.kind    = kind;
    q_cmd.value   = (kind == K_DEC) ? masked : value;
    q_cmd.upper   = (opcode == OP_HEX_UPPER);
    q_cmd.prefix  = flags[FLAG_PREFIX];
    q_cmd.hex_top = (flags[FLAG_PAD] && value != 32'd0) ? nib_max : top_found;
  end

  assign src_stall = q_full;
  assign q_push    = src_valid && !q_full;

endmodule

/* design/itoa_queue.sv */
// short command queue between front and back end
// depends on itoa_pkg
`timescale 1ns / 1ps

module itoa_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  itoa_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output itoa_pkg::cmd_t    head_cmd
);
  import itoa_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/itoa_back.sv */
// back end: binary to bcd conversion and character output register
// depends on itoa_pkg
`timescale 1ns / 1ps

module itoa_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  itoa_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [6:0]        char_code,
  output logic              last,
  output logic              error
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_PREFIX,
    S_DIGITS
  } state_t;

  state_t      state;
  logic        is_dec;
  logic        upper;
  logic        prefix;
  logic        pre_pos;
  logic [3:0]  idx;
  logic [4:0]  cnt;
  logic [31:0] bin;
  logic [39:0] bcd;
  logic        can_emit;
  logic        out_load;
  logic [39:0] bcd_adj;
  logic [3:0]  dec_top;
  logic [3:0]  hex_nib;
  logic [3:0]  dec_nib;
  logic [6:0]  hex_char;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < 10; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3
                                                  : bcd[4*d +: 4];
    end
  end

  // most significant nonzero decimal digit
  always_comb begin
    dec_top = 4'd0;
    for (int d = 0; d < 10; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        dec_top = 4'(d);
      end
    end
  end

  assign hex_nib = bin[{idx[2:0], 2'b00} +: 4];
  assign dec_nib = bcd[{idx, 2'b00} +: 4];

  always_comb begin
    if (hex_nib < 4'd10) begin
      hex_char = CH_ZERO + {3'b0, hex_nib};
    end else begin
      hex_char = (upper ? CH_UPPER : CH_LOWER) + {3'b0, hex_nib} - 7'd10;
    end
  end

  assign can_emit = !res_valid || !res_stall;
  assign q_pop    = (state == S_IDLE) && q_valid && (q_cmd.kind != K_ERR || can_emit);

  // a character enters the output register this cycle
  assign out_load = can_emit && ((state == S_IDLE && q_pop && q_cmd.kind == K_ERR) ||
                                 state == S_PREFIX || state == S_DIGITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      res_valid <= out_load || (res_valid && res_stall);
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            upper   <= q_cmd.upper;
            prefix  <= q_cmd.prefix;
            pre_pos <= 1'b0;
            bin     <= q_cmd.value;
            case (q_cmd.kind)
              K_HEX: begin
                is_dec <= 1'b0;
                idx    <= {1'b0, q_cmd.hex_top};
                state  <= q_cmd.prefix ? S_PREFIX : S_DIGITS;
              end
              K_DEC: begin
                is_dec <= 1'b1;
                bcd    <= '0;
                cnt    <= '0;
                state  <= S_CONV;
              end
              default: begin
                char_code <= CH_NUL;
                last      <= 1'b1;
                error     <= 1'b1;
              end
            endcase
          end
        end
        S_CONV: begin
          bcd <= {bcd_adj[38:0], bin[31]};
          bin <= {bin[30:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx   <= dec_top;
          state <= prefix ? S_PREFIX : S_DIGITS;
        end
        S_PREFIX: begin
          if (can_emit) begin
            last      <= 1'b0;
            error     <= 1'b0;
            if (is_dec) begin
              char_code <= CH_MINUS;
              state     <= S_DIGITS;
            end else if (!pre_pos) begin
              char_code <= CH_ZERO;
              pre_pos   <= 1'b1;
            end else begin
              char_code <= CH_X;
              state     <= S_DIGITS;
            end
          end
        end
        S_DIGITS: begin
          if (can_emit) begin
            char_code <= is_dec ? CH_ZERO + {3'b0, dec_nib} : hex_char;
            last      <= (idx == 4'd0);
            error     <= 1'b0;
            idx       <= idx - 1'b1;
            if (idx == 4'd0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/integer_to_ascii_formatter_top.sv */
// integer to ascii formatter, top level
// depends on itoa_pkg, itoa_front, itoa_queue, itoa_back
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   src      | src_valid/src_stall  | value, size_code, opcode, flags
//   res      | res_valid/res_stall  | char_code, last, error
//
// hex item: leaves the queue, then one character per cycle unless res is
//   stalled (prefix plus 1 to 8 nibbles); an error item is a single result
// decimal item: leaves the queue, 32 shift-and-add-3 steps, a digit scan,
//   then one character per cycle unless res is stalled (up to 11)
// reset: synchronous, clears queue pointers, back-end state and res_valid
// the two-entry queue lets src items in while the back end is busy or stalled
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [31:0] value,
  input  logic [1:0]  size_code,
  input  logic [1:0]  opcode,
  input  logic [1:0]  flags,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [6:0]  char_code,
  output logic        last,
  output logic        error
);
  import itoa_pkg::*;

  // front to queue
  logic q_full;
  logic q_push;
  cmd_t push_cmd;

  // queue to back
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  // classify items and mask decimal values
  itoa_front u_front (
    .src_valid (src_valid),
    .src_stall (src_stall),
    .value     (value),
    .size_code (size_code),
    .opcode    (opcode),
    .flags     (flags),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // decouples item intake from character output
  itoa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // conversion; one character per cycle into output register unless stalled
  itoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .char_code (char_code),
    .last      (last),
    .error     (error)
  );

endmodule

/* design/itoa_checker.sv */
// port-level checks of the integer to ascii formatter, bound to the top level
// depends on assert_macros.svh, itoa_pkg and integer_to_ascii_formatter_top
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itoa_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [6:0] char_code,
  input logic       last,
  input logic       error
);
  import itoa_pkg::*;

  logic [8:0] res_word;
  logic       res_held;
  logic       char_ok;

  assign res_word = {char_code, last, error};
  assign res_held = res_valid && res_stall;

  // digits, hex letters, x or minus
  always_comb begin
    char_ok = char_code inside {[CH_ZERO : CH_ZERO + 7'd9], [CH_UPPER : CH_UPPER + 7'd5],
                                [CH_LOWER : CH_LOWER + 7'd5], CH_X, CH_MINUS};
  end

  // stalled result holds
  `ITOA_CHECK(a_res_hold, res_held |=> res_valid && $stable(res_word), "stalled result changed")

  // an error result is a lone nul marked last
  `ITOA_CHECK(a_err_form, res_valid && error |-> last && char_code == CH_NUL, "bad error result")

  // normal characters are digits, hex letters, x or minus
  `ITOA_CHECK(a_char_set, res_valid && !error |-> char_ok, "unexpected character")

  // reset empties the output register
  `ITOA_CHECK_RST(a_rst_clear, rst |=> !res_valid, "result valid after reset")

endmodule

bind integer_to_ascii_formatter_top itoa_checker u_itoa_checker (.*);
